// File: rtl/hll_pkg.sv
// Shared codes, constants and the key hash step of the cardinality sketch.
package hll_pkg;

	// Command carried in tuser of the input stream
	typedef enum logic [1:0] {
		CMD_KEY   = 2'd0,
		CMD_EMPTY = 2'd1,
		CMD_MERGE = 2'd2,
		CMD_COUNT = 2'd3
	} cmd_t;

	// Configuration port
	localparam int          APB_AW          = 3;
	localparam logic [2:0]  ADDR_PRECISION  = 3'd0;
	localparam logic [3:0]  PRECISION_RESET = 4'd14;

	// Hash constants
	localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
	localparam logic [63:0] MIX_C1    = 64'hFF51AFD7ED558CCD;
	localparam logic [63:0] MIX_C2    = 64'hC4CEB9FE1A85EC53;

	// Estimator constants
	localparam logic [31:0] LN2_Q32     = 32'hB17217F8;
	localparam logic [63:0] ALPHA_P4    = 64'd673;
	localparam logic [63:0] ALPHA_P5    = 64'd697;
	localparam logic [63:0] ALPHA_P6    = 64'd709;
	localparam logic [63:0] ALPHA_DEN_S = 64'd1000;
	localparam logic [63:0] ALPHA_NUM_K = 64'd7213;
	localparam logic [63:0] ALPHA_DEN_K = 64'd10000;
	localparam logic [63:0] ALPHA_DEN_C = 64'd10790;
	localparam logic [63:0] LARGE_HI    = 64'd1 << 48;
	localparam logic [63:0] LARGE_LO    = (64'd1 << 48) / 30;

	// One FNV-1a 64 step; the prime is 2^40 + 0x1B3
	function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
		logic [63:0] x;
		x = h ^ {56'd0, b};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

endpackage

// File: rtl/hyperloglog_cardinality_sketch_top.sv
// Top level of the cardinality sketch: hashing, register file and estimator sequencer.
//
// Channel  | Dir | Handshake          | Word
// s_*      | in  | s_tvalid/s_tready  | command, key byte, last flag, merge slot and value
// m_*      | out | m_tvalid/m_tready  | 64-bit rounded estimate
// apb      | in  | psel/penable       | precision_bits at byte address 0
//
// A key byte that is not last is folded into the running hash. A last byte or an empty key
// runs the mix multiplications, a setup step and a leading-zero search one bit at a time,
// then a read-modify-write. A merge with an index in range does the same read-modify-write.
// A count walks 2^p registers, one a cycle on the memory read port, then runs up to three
// divisions and up to two logarithms (normalize, then repeated squaring) on one shared
// 32x32 multiplier and one restoring divider. After reset a clearing pass over all
// 2^MAX_PRECISION registers zeroes them while s_tready stays low.
// The result waits in an output register; a new item is taken meanwhile.
module hyperloglog_cardinality_sketch_top #(
	parameter int MAX_PRECISION = 14
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [hll_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// [7:0] data_byte, [21:8] register_index, [27:22] register_value, [31:28] zero
	input  logic [31:0]               s_tdata,
	// [1:0] command
	input  logic [1:0]                s_tuser,
	input  logic                      s_tlast,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// [63:0] estimate
	output logic [63:0]               m_tdata
);
	import hll_pkg::*;

	localparam int AW   = MAX_PRECISION;
	localparam int NREG = 1 << AW;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_MUL, S_RHOSET, S_RHO, S_RD, S_WR, S_WALK, S_WLAST, S_ZCHK,
		S_SETEST, S_DIVCHK, S_DIV, S_DIVEND, S_LINCHK, S_LRGCHK, S_NORM, S_SQ, S_L2,
		S_LN, S_ROUND, S_OUT
	} state_t;

	typedef enum logic [1:0] {D_ALPHA, D_EST, D_EST2} div_op_t;
	typedef enum logic {L_LIN, L_LRG} log_op_t;

	state_t      state_q;
	div_op_t     div_op_q;
	log_op_t     log_op_q;
	logic [3:0]  prec_q;
	logic [63:0] hash_q;
	logic [63:0] k_q;
	logic [63:0] acc_q;
	logic [63:0] prod_q;
	logic [1:0]  mstep_q;
	logic        fphase_q;
	logic [63:0] sh_q;
	logic [5:0]  ncnt_q;
	logic [AW-1:0] rmw_addr_q;
	logic [5:0]  rmw_val_q;
	logic [AW-1:0] wcnt_q;
	logic        walk_v_s1;
	logic [63:0] z_q;
	logic [AW:0] zeros_q;
	logic [63:0] rem_q;
	logic [63:0] dq_q;
	logic [63:0] dv_q;
	logic [5:0]  dcnt_q;
	logic        second_q;
	logic [31:0] alpha_q;
	logic [63:0] est_q;
	logic [31:0] y_q;
	logic [21:0] lr_q;
	logic [21:0] l2_q;
	logic [3:0]  lcnt_q;
	logic [63:0] res_q;
	logic [63:0] out_q;
	logic        out_v_q;
	logic [5:0]  rd_q;

	logic [5:0]  sketch_mem [NREG];

	logic [4:0]   p_eff;
	logic [AW-1:0] m_mask;
	logic [31:0]  mul_a, mul_b;
	logic [63:0]  mul_fin;
	logic [63:0]  mix_c;
	logic         div_carry, div_take;
	logic [63:0]  div_rem2, div_rem_n;
	logic [6:0]   shamt;
	logic [127:0] ws;
	logic [63:0]  rho_v;
	logic [AW-1:0] bucket;
	logic [31:0]  yn;
	logic [31:0]  lnv;
	logic [63:0]  lnsum;
	logic [63:0]  z_term;
	logic         mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [5:0]   mem_wdata;
	logic         in_acc;
	cmd_t         in_cmd;
	logic [7:0]   in_byte;
	logic [13:0]  in_idx;
	logic [5:0]   in_val;
	logic [63:0]  hnew;
	logic [63:0]  alpha_num, alpha_den;
	logic         cfg_wr;

	// Unpack the input word
	assign in_cmd  = cmd_t'(s_tuser);
	assign in_byte = s_tdata[7:0];
	assign in_idx  = s_tdata[21:8];
	assign in_val  = s_tdata[27:22];
	assign in_acc  = s_tvalid && s_tready;
	assign hnew    = fnv_step(hash_q, in_byte);

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_PRECISION);
	assign prdata = (paddr == ADDR_PRECISION) ? {28'd0, prec_q} : 32'd0;

	// Clamp precision to the supported range
	always_comb begin
		if (prec_q < 4'd4) begin
			p_eff = 5'd4;
		end else if ({1'b0, prec_q} > 5'(MAX_PRECISION)) begin
			p_eff = 5'(MAX_PRECISION);
		end else begin
			p_eff = {1'b0, prec_q};
		end
	end
	assign m_mask = AW'((32'd1 << p_eff) - 32'd1);

	// Shared multiplier operand select
	assign mix_c = fphase_q ? MIX_C2 : MIX_C1;
	always_comb begin
		mul_a = 32'd0;
		mul_b = 32'd0;
		case (state_q)
			S_MUL: begin
				case (mstep_q)
					2'd0: begin mul_a = k_q[31:0];  mul_b = mix_c[31:0];  end
					2'd1: begin mul_a = k_q[31:0];  mul_b = mix_c[63:32]; end
					default: begin mul_a = k_q[63:32]; mul_b = mix_c[31:0]; end
				endcase
			end
			S_SQ: begin mul_a = y_q; mul_b = y_q; end
			S_LN: begin mul_a = {10'd0, l2_q}; mul_b = LN2_Q32; end
			default: begin mul_a = 32'd0; mul_b = 32'd0; end
		endcase
	end
	assign mul_fin = acc_q + {prod_q[31:0], 32'd0};

	// Restoring divider step
	assign div_carry = rem_q[63];
	assign div_rem2  = {rem_q[62:0], dq_q[63]};
	assign div_take  = div_carry || (div_rem2 >= dv_q);
	assign div_rem_n = div_take ? (div_rem2 - dv_q) : div_rem2;

	// Alpha shifted into the 128-bit dividend
	assign shamt = {1'b0, p_eff, 1'b0} + (second_q ? 7'd16 : 7'd32);
	assign ws    = {96'd0, alpha_q} << shamt;

	// Bucket and remaining bits of the final hash
	assign rho_v  = k_q << p_eff;
	assign bucket = AW'(k_q[63 -: AW] >> (5'(AW) - p_eff));

	// Squaring and ln helpers
	assign yn    = prod_q[61:30];
	assign lnsum = prod_q + 64'h0000_0000_8000_0000;
	assign lnv   = lnsum[63:32];

	// Harmonic sum term for the register read during the walk
	assign z_term = (rd_q <= 6'd48) ? (64'd1 << (6'd48 - rd_q)) : 64'd0;

	// Alpha numerator and denominator per precision
	always_comb begin
		case (p_eff)
			5'd4: begin alpha_num = ALPHA_P4; alpha_den = ALPHA_DEN_S; end
			5'd5: begin alpha_num = ALPHA_P5; alpha_den = ALPHA_DEN_S; end
			5'd6: begin alpha_num = ALPHA_P6; alpha_den = ALPHA_DEN_S; end
			default: begin
				alpha_num = ALPHA_NUM_K << p_eff;
				alpha_den = (ALPHA_DEN_K << p_eff) + ALPHA_DEN_C;
			end
		endcase
	end

	// Register memory ports
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = rmw_addr_q;
		mem_wdata = rmw_val_q;
		mem_raddr = rmw_addr_q;
		case (state_q)
			S_CLR: begin mem_we = 1'b1; mem_waddr = wcnt_q; mem_wdata = 6'd0; end
			S_WR: mem_we = (rmw_val_q > rd_q);
			S_WALK: mem_raddr = wcnt_q;
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			sketch_mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= sketch_mem[mem_raddr];
	end

	// Product register of the shared multiplier
	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			div_op_q   <= D_ALPHA;
			log_op_q   <= L_LIN;
			prec_q     <= PRECISION_RESET;
			hash_q     <= FNV_BASIS;
			k_q        <= 64'd0;
			acc_q      <= 64'd0;
			mstep_q    <= 2'd0;
			fphase_q   <= 1'b0;
			sh_q       <= 64'd0;
			ncnt_q     <= 6'd0;
			rmw_addr_q <= '0;
			rmw_val_q  <= 6'd0;
			wcnt_q     <= '0;
			walk_v_s1  <= 1'b0;
			z_q        <= 64'd0;
			zeros_q    <= '0;
			rem_q      <= 64'd0;
			dq_q       <= 64'd0;
			dv_q       <= 64'd0;
			dcnt_q     <= 6'd0;
			second_q   <= 1'b0;
			alpha_q    <= 32'd0;
			est_q      <= 64'd0;
			y_q        <= 32'd0;
			lr_q       <= 22'd0;
			l2_q       <= 22'd0;
			lcnt_q     <= 4'd0;
			res_q      <= 64'd0;
			out_q      <= 64'd0;
			out_v_q    <= 1'b0;
		end else begin
			if (cfg_wr) begin
				prec_q <= pwdata[3:0];
			end

			// Load the output word or drop it once taken
			if (state_q == S_OUT && (!out_v_q || m_tready)) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && m_tready) begin
				out_v_q <= 1'b0;
			end

			// Fold the walked register into the sum
			walk_v_s1 <= (state_q == S_WALK);
			if (walk_v_s1) begin
				z_q <= z_q + z_term;
				if (rd_q == 6'd0) begin
					zeros_q <= zeros_q + 1'b1;
				end
			end

			case (state_q)
				S_CLR: begin
					wcnt_q <= wcnt_q + 1'b1;
					if (wcnt_q == AW'(NREG - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						case (in_cmd)
							CMD_KEY: begin
								if (s_tlast) begin
									hash_q   <= FNV_BASIS;
									k_q      <= hnew ^ (hnew >> 33);
									fphase_q <= 1'b0;
									mstep_q  <= 2'd0;
									state_q  <= S_MUL;
								end else begin
									hash_q <= hnew;
								end
							end
							CMD_EMPTY: begin
								k_q      <= FNV_BASIS ^ (FNV_BASIS >> 33);
								fphase_q <= 1'b0;
								mstep_q  <= 2'd0;
								state_q  <= S_MUL;
							end
							CMD_MERGE: begin
								if ({18'd0, in_idx} < (32'd1 << p_eff) && {18'd0, in_idx} < NREG) begin
									rmw_addr_q <= AW'(in_idx);
									rmw_val_q  <= in_val;
									state_q    <= S_RD;
								end
							end
							CMD_COUNT: begin
								wcnt_q  <= '0;
								z_q     <= 64'd0;
								zeros_q <= '0;
								state_q <= S_WALK;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				// Low 64 bits of k times the mix constant over three partial products
				S_MUL: begin
					case (mstep_q)
						2'd0: begin
							acc_q   <= 64'd0;
							mstep_q <= 2'd1;
						end
						2'd1: begin
							acc_q   <= prod_q;
							mstep_q <= 2'd2;
						end
						2'd2: begin
							acc_q   <= mul_fin;
							mstep_q <= 2'd3;
						end
						default: begin
							k_q     <= mul_fin ^ (mul_fin >> 33);
							mstep_q <= 2'd0;
							if (fphase_q) begin
								state_q <= S_RHOSET;
							end else begin
								fphase_q <= 1'b1;
							end
						end
					endcase
				end
				S_RHOSET: begin
					rmw_addr_q <= bucket;
					sh_q       <= rho_v;
					if (rho_v == 64'd0) begin
						rmw_val_q <= 6'(7'd65 - {2'd0, p_eff});
						state_q   <= S_RD;
					end else begin
						rmw_val_q <= 6'd1;
						state_q   <= S_RHO;
					end
				end
				// Count leading zeros one bit a cycle
				S_RHO: begin
					if (sh_q[63]) begin
						state_q <= S_RD;
					end else begin
						sh_q      <= sh_q << 1;
						rmw_val_q <= rmw_val_q + 1'b1;
					end
				end
				S_RD: state_q <= S_WR;
				S_WR: state_q <= S_IDLE;
				S_WALK: begin
					wcnt_q <= wcnt_q + 1'b1;
					if (wcnt_q == m_mask) begin
						state_q <= S_WLAST;
					end
				end
				S_WLAST: state_q <= S_ZCHK;
				S_ZCHK: begin
					if (z_q == 64'd0) begin
						res_q   <= '1;
						state_q <= S_OUT;
					end else begin
						rem_q    <= 64'd0;
						dq_q     <= (alpha_num << 32) + (alpha_den >> 1);
						dv_q     <= alpha_den;
						div_op_q <= D_ALPHA;
						state_q  <= S_DIVCHK;
					end
				end
				S_SETEST: begin
					rem_q   <= ws[127:64];
					dq_q    <= ws[63:0];
					dv_q    <= z_q;
					state_q <= S_DIVCHK;
				end
				S_DIVCHK: begin
					if (rem_q >= dv_q) begin
						if (div_op_q == D_EST) begin
							second_q <= 1'b1;
							div_op_q <= D_EST2;
							state_q  <= S_SETEST;
						end else begin
							res_q   <= '1;
							state_q <= S_OUT;
						end
					end else begin
						dcnt_q  <= 6'd0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q  <= div_rem_n;
					dq_q   <= {dq_q[62:0], div_take};
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == 6'd63) begin
						state_q <= S_DIVEND;
					end
				end
				S_DIVEND: begin
					case (div_op_q)
						D_ALPHA: begin
							alpha_q  <= dq_q[31:0];
							second_q <= 1'b0;
							div_op_q <= D_EST;
							state_q  <= S_SETEST;
						end
						D_EST: begin
							est_q   <= dq_q;
							state_q <= S_LINCHK;
						end
						default: begin
							res_q   <= dq_q;
							state_q <= S_OUT;
						end
					endcase
				end
				// Linear counting for small estimates
				S_LINCHK: begin
					if (est_q <= (64'd5 << (p_eff + 5'd15)) && zeros_q != '0) begin
						sh_q     <= 64'(zeros_q);
						ncnt_q   <= 6'd63;
						log_op_q <= L_LIN;
						state_q  <= S_NORM;
					end else begin
						state_q <= S_LRGCHK;
					end
				end
				// Large-range correction
				S_LRGCHK: begin
					if (est_q > LARGE_LO && est_q < LARGE_HI) begin
						sh_q     <= LARGE_HI - est_q;
						ncnt_q   <= 6'd63;
						log_op_q <= L_LRG;
						state_q  <= S_NORM;
					end else begin
						state_q <= S_ROUND;
					end
				end
				// Normalize for log2, one bit a cycle
				S_NORM: begin
					if (ncnt_q != 6'd0 && !sh_q[63]) begin
						sh_q   <= sh_q << 1;
						ncnt_q <= ncnt_q - 1'b1;
					end else begin
						y_q     <= {1'b0, sh_q[63:33]};
						lr_q    <= {ncnt_q, 16'd0};
						lcnt_q  <= 4'd15;
						mstep_q <= 2'd0;
						state_q <= S_SQ;
					end
				end
				// One fraction bit per square
				S_SQ: begin
					if (mstep_q == 2'd0) begin
						mstep_q <= 2'd1;
					end else begin
						mstep_q <= 2'd0;
						if (yn[31]) begin
							y_q          <= yn >> 1;
							lr_q[lcnt_q] <= 1'b1;
						end else begin
							y_q <= yn;
						end
						if (lcnt_q == 4'd0) begin
							state_q <= S_L2;
						end else begin
							lcnt_q <= lcnt_q - 1'b1;
						end
					end
				end
				S_L2: begin
					l2_q    <= ((log_op_q == L_LIN) ? {1'b0, p_eff, 16'd0} : 22'(48 << 16)) - lr_q;
					mstep_q <= 2'd0;
					state_q <= S_LN;
				end
				S_LN: begin
					if (mstep_q == 2'd0) begin
						mstep_q <= 2'd1;
					end else begin
						mstep_q <= 2'd0;
						if (log_op_q == L_LIN) begin
							est_q   <= 64'(lnv) << p_eff;
							state_q <= S_LRGCHK;
						end else begin
							est_q   <= {lnv, 32'd0};
							state_q <= S_ROUND;
						end
					end
				end
				S_ROUND: begin
					res_q   <= (est_q >> 16) + {63'd0, est_q[15]};
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_v_q || m_tready) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A count query closes the input until its estimate is produced
	a_count_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_cmd == CMD_COUNT) |=> !s_tready)
		else $error("input open after count query");

	// The register walk never writes the register memory
	a_walk_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> !mem_we)
		else $error("memory write during walk");

	// A result shows up only from the output step
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_OUT))
		else $error("result without output step");

endmodule

// File: verif/hyperloglog_cardinality_sketch_top_tb.sv
// Self-checking testbench for the cardinality sketch: hashing, merges and count estimates.
`timescale 1ns / 100ps

module hyperloglog_cardinality_sketch_top_tb;
	import hll_pkg::*;

	localparam int NREG = 1 << 14;
	localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;
	localparam logic [63:0] ALL_ONES = '1;

	typedef struct {
		cmd_t        cmd;
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [13:0] reg_index;
		logic [5:0]  reg_value;
	} sketch_word_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid, s_tready, s_tlast;
	logic [31:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid, m_tready;
	logic [63:0] m_tdata;

	// Predictor state
	logic [5:0]  model_regs [NREG];
	logic [63:0] model_hash;
	logic [3:0]  model_prec;

	sketch_word_t pending_words [$];
	logic [63:0]  expected_estimates [$];
	int  fail_count;
	int  count_results;
	int  merge_words;
	int  key_words;
	int  hold_cycles;

	hyperloglog_cardinality_sketch_top dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("Test completed with failures");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	function automatic int eff_prec();
		int p;
		p = model_prec;
		if (p < 4) p = 4;
		if (p > 14) p = 14;
		return p;
	endfunction

	function automatic logic [63:0] fmix64(input logic [63:0] k);
		k = k ^ (k >> 33);
		k = k * MIX_C1;
		k = k ^ (k >> 33);
		k = k * MIX_C2;
		k = k ^ (k >> 33);
		return k;
	endfunction

	// Hash to bucket, count leading zeros, keep the max
	function automatic void absorb_hash(input logic [63:0] raw);
		int p, rho, bucket;
		logic [63:0] h, v;
		p = eff_prec();
		h = fmix64(raw);
		bucket = int'(h >> (64 - p));
		v = h << p;
		if (v == 0) rho = 65 - p;
		else begin
			rho = 1;
			while (!v[63]) begin
				rho++;
				v = v << 1;
			end
		end
		if (rho > model_regs[bucket]) model_regs[bucket] = 6'(rho);
	endfunction

	function automatic logic [63:0] alpha_q32(input int p);
		logic [127:0] m, num, den;
		if (p == 4) return 64'(((128'd673 << 32) + 500) / 1000);
		if (p == 5) return 64'(((128'd697 << 32) + 500) / 1000);
		if (p == 6) return 64'(((128'd709 << 32) + 500) / 1000);
		m = 128'd1 << p;
		num = (128'd7213 * m) << 32;
		den = 128'd10 * (128'd1000 * m + 128'd1079);
		return 64'((num + den / 2) / den);
	endfunction

	function automatic logic [63:0] log2_q16(input logic [63:0] x);
		int n;
		logic [63:0] y, r;
		n = 63;
		while (n > 0 && !x[n]) n--;
		y = (n >= 30) ? (x >> (n - 30)) : (x << (30 - n));
		r = 64'(n) << 16;
		for (int i = 15; i >= 0; i--) begin
			y = (y * y) >> 30;
			if (y >= (64'd1 << 31)) begin
				y = y >> 1;
				r[i] = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic logic [63:0] ln_q16(input logic [63:0] l2);
		return (l2 * 64'(LN2_Q32) + 64'h80000000) >> 32;
	endfunction

	// Harmonic mean estimate with small and large range corrections
	function automatic logic [63:0] predict_estimate();
		int p;
		logic [63:0] m, z, zeros, est, l2, rest;
		logic [127:0] num;
		p = eff_prec();
		m = 64'd1 << p;
		z = 0;
		zeros = 0;
		for (int i = 0; i < int'(m); i++) begin
			if (model_regs[i] == 0) zeros++;
			if (model_regs[i] <= 48) z += 64'd1 << (48 - model_regs[i]);
		end
		if (z == 0) return ALL_ONES;
		num = 128'(alpha_q32(p)) << (2 * p + 32);
		if ((num >> 64) >= z) begin
			num = (128'(alpha_q32(p)) << (2 * p + 16)) / z;
			return (num >> 64) != 0 ? ALL_ONES : num[63:0];
		end
		est = 64'(num / z);
		if (est <= ((5 * m) << 15) && zeros > 0) begin
			l2 = (64'(p) << 16) - log2_q16(zeros);
			est = m * ln_q16(l2);
		end
		if (est > LARGE_LO && est < LARGE_HI) begin
			rest = LARGE_HI - est;
			l2 = (64'd48 << 16) - log2_q16(rest);
			est = ln_q16(l2) << 32;
		end
		return (est >> 16) + ((est >> 15) & 64'd1);
	endfunction

	// Advance the predictor by one accepted word
	function automatic void predict_word(input sketch_word_t w);
		case (w.cmd)
			CMD_KEY: begin
				model_hash = (model_hash ^ {56'd0, w.data_byte}) * FNV_PRIME;
				if (w.last_byte) begin
					absorb_hash(model_hash);
					model_hash = FNV_BASIS;
				end
			end
			CMD_EMPTY: absorb_hash(FNV_BASIS);
			CMD_MERGE: begin
				if (int'(w.reg_index) < (1 << eff_prec()) &&
						w.reg_value > model_regs[w.reg_index])
					model_regs[w.reg_index] = w.reg_value;
			end
			default: expected_estimates.push_back(predict_estimate());
		endcase
	endfunction

	function automatic sketch_word_t mk(input cmd_t c, input logic [7:0] b, input logic l,
			input logic [13:0] idx, input logic [5:0] val);
		sketch_word_t w;
		w.cmd = c;
		w.data_byte = b;
		w.last_byte = l;
		w.reg_index = idx;
		w.reg_value = val;
		return w;
	endfunction

	sketch_word_t cur_word;
	logic s_tready_q;
	always @(posedge clk) begin
		s_tready_q <= s_tvalid && s_tready;
	end

	// Driver: offer queued words with random gaps
	int drive_gap;
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready_q) begin
				predict_word(cur_word);
				s_tvalid <= 1'b0;
				drive_gap = $urandom_range(0, 3);
			end else if (!s_tvalid) begin
				if (drive_gap > 0) drive_gap--;
				else if (pending_words.size() > 0) begin
					cur_word = pending_words.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= cur_word.cmd;
					s_tlast <= cur_word.last_byte;
					s_tdata <= {4'd0, cur_word.reg_value, cur_word.reg_index,
						cur_word.data_byte};
				end
			end
		end
	end

	// Monitor: compare each estimate with the oldest expectation
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (expected_estimates.size() == 0)
				report_mismatch("unexpected estimate", m_tdata, 64'd0);
			else begin
				logic [63:0] want;
				want = expected_estimates.pop_front();
				if (m_tdata !== want) report_mismatch("estimate", m_tdata, want);
				count_results++;
			end
		end
	end

	// Receiver stalls, with one long hold-off
	int stall_left;
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			m_tready <= 1'b0;
		end else if (m_tvalid && m_tready) begin
			stall_left = $urandom_range(0, 3);
			m_tready <= (stall_left == 0);
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= (stall_left == 0);
		end else
			m_tready <= 1'b1;
	end

	task automatic apb_write(input logic [3:0] val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= ADDR_PRECISION;
		pwdata <= {28'd0, val};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		model_prec = val;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_words.size() > 0 || s_tvalid || expected_estimates.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	// Queue one key of the given length with random bytes
	task automatic queue_key(input int len);
		for (int i = 0; i < len; i++)
			pending_words.push_back(mk(CMD_KEY, 8'($urandom), i == len - 1,
				14'($urandom), 6'($urandom)));
		key_words += len;
	endtask

	task automatic queue_random(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 60) queue_key($urandom_range(1, 6));
			else if (r < 65) pending_words.push_back(mk(CMD_EMPTY, 8'($urandom), 1'($urandom),
				14'($urandom), 6'($urandom)));
			else if (r < 88) begin
				pending_words.push_back(mk(CMD_MERGE, 8'($urandom), 1'($urandom),
					($urandom_range(0, 3) == 0) ? 14'($urandom) :
					14'($urandom_range(0, (1 << eff_prec()) - 1)),
					($urandom_range(0, 5) == 0) ? 6'($urandom) : 6'($urandom_range(0, 20))));
				merge_words++;
			end else pending_words.push_back(mk(CMD_COUNT, 8'($urandom), 1'($urandom),
				14'($urandom), 6'($urandom)));
		end
	endtask

	initial begin
		logic [3:0] precs [6];
		precs = '{4'd0, 4'd4, 4'd15, 4'd6, 4'd5, 4'd9};
		fail_count = 0;
		count_results = 0;
		merge_words = 0;
		key_words = 0;
		hold_cycles = 0;
		drive_gap = 0;
		stall_left = 0;
		for (int i = 0; i < NREG; i++) model_regs[i] = '0;
		model_hash = FNV_BASIS;
		model_prec = PRECISION_RESET;
		arst_n = 1'b0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		s_tvalid = 0; s_tdata = '0; s_tuser = CMD_KEY; s_tlast = 0;
		m_tready = 1'b1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty sketch, extremes, merges at the top index and above 61
		pending_words.push_back(mk(CMD_COUNT, 8'h00, 1'b0, 14'h0000, 6'h00));
		pending_words.push_back(mk(CMD_KEY, 8'hFF, 1'b0, 14'h3FFF, 6'h3F));
		pending_words.push_back(mk(CMD_EMPTY, 8'h00, 1'b0, 14'h0000, 6'h00));
		pending_words.push_back(mk(CMD_KEY, 8'h00, 1'b1, 14'h0000, 6'h00));
		pending_words.push_back(mk(CMD_MERGE, 8'hFF, 1'b1, 14'h3FFF, 6'h3F));
		pending_words.push_back(mk(CMD_MERGE, 8'h00, 1'b0, 14'h0000, 6'd62));
		pending_words.push_back(mk(CMD_MERGE, 8'h00, 1'b0, 14'h0001, 6'd1));
		pending_words.push_back(mk(CMD_COUNT, 8'hFF, 1'b1, 14'h3FFF, 6'h3F));
		wait_drained();

		// Saturate every register of a small sketch: zero harmonic sum
		apb_write(4'd4);
		for (int i = 0; i < 16; i++)
			pending_words.push_back(mk(CMD_MERGE, 8'd0, 1'b0, 14'(i), 6'd60));
		pending_words.push_back(mk(CMD_COUNT, 8'd0, 1'b0, 14'd0, 6'd0));
		// Mid-size registers: raise every register in steps up to 48, left for the next counts
		for (int v = 20; v <= 48; v += 4) begin
			for (int i = 0; i < 16; i++)
				pending_words.push_back(mk(CMD_MERGE, 8'd0, 1'b0, 14'(i), 6'(v)));
		end
		wait_drained();

		// Random phases through several precisions
		foreach (precs[k]) begin
			apb_write(precs[k]);
			if (k == 1) begin
				// Hold the receiver while two estimates back up into the block
				hold_cycles = 3000;
				pending_words.push_back(mk(CMD_COUNT, 8'd0, 1'b0, 14'd0, 6'd0));
				pending_words.push_back(mk(CMD_COUNT, 8'd0, 1'b0, 14'd0, 6'd0));
			end
			queue_random(40);
			pending_words.push_back(mk(CMD_COUNT, 8'd0, 1'b0, 14'd0, 6'd0));
			wait_drained();
		end
		apb_write(4'd14);
		for (int j = 0; j < 10; j++) begin
			for (int i = 0; i < 6; i++)
				pending_words.push_back(mk(CMD_MERGE, 8'd0, 1'b0,
					14'($urandom), 6'($urandom_range(0, 61))));
			pending_words.push_back(mk(CMD_COUNT, 8'd0, 1'b0, 14'd0, 6'd0));
		end
		wait_drained();

		$display("Covered %0d key bytes, %0d merges, %0d estimates checked",
			key_words, merge_words, count_results);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: files.f
rtl/hll_pkg.sv
rtl/hyperloglog_cardinality_sketch_top.sv
verif/hyperloglog_cardinality_sketch_top_tb.sv
